### rtl/bgr2yuv_pkg.sv
// Shared types and constants for the BGR to YUV 4:2:0 pixel converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package bgr2yuv_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION);   // counter width
    localparam int SIZE_W        = 13;                      // frame size register width
    localparam int CFG_INDEX_W   = 2;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = 18;                      // signed weighted sum

    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_DIMENSION);
    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [PIX_W-1:0] LUMA_OFFSET   = PIX_W'(16);
    localparam logic [PIX_W-1:0] CHROMA_OFFSET = PIX_W'(128);

    typedef enum logic [1:0] {
        CHROMA_NONE = 2'd0,
        CHROMA_U    = 2'd1,
        CHROMA_V    = 2'd2
    } chroma_kind_t;

    // Position-derived tag carried alongside the pixel
    typedef struct packed {
        chroma_kind_t kind;
        logic         eof;
    } pix_tag_t;

    // Floor(sum / 256) + offset, modulo 256: bits [15:8] of the sum plus offset
    function automatic logic [PIX_W-1:0] scale8(input logic signed [SUM_W-1:0] sum,
                                                input logic [PIX_W-1:0] offset);
        scale8 = sum[15:8] + offset;
    endfunction

endpackage

`default_nettype wire

### rtl/bgr2yuv_math.sv
// BT.601 integer color transform for one pixel (combinational).
// Depends on bgr2yuv_pkg.
`default_nettype none

module bgr2yuv_math
    import bgr2yuv_pkg::*;
(
    input  wire logic [PIX_W-1:0] blue,
    input  wire logic [PIX_W-1:0] green,
    input  wire logic [PIX_W-1:0] red,
    input  wire chroma_kind_t     kind,
    output logic      [PIX_W-1:0] luma,
    output logic      [PIX_W-1:0] chroma
);

    logic signed [SUM_W-1:0] b_s, g_s, r_s;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

    assign b_s = $signed({(SUM_W-PIX_W)'(0), blue});
    assign g_s = $signed({(SUM_W-PIX_W)'(0), green});
    assign r_s = $signed({(SUM_W-PIX_W)'(0), red});

    // Constant-coefficient products; synthesis folds them into shift/add trees
    assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
    assign u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
    assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;

    assign luma = scale8(y_sum, LUMA_OFFSET);

    always_comb
    begin
        unique case (kind)
            CHROMA_U: chroma = scale8(u_sum, CHROMA_OFFSET);
            CHROMA_V: chroma = scale8(v_sum, CHROMA_OFFSET);
            default:  chroma = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/bgr_to_yuv420_pixel_converter.sv
// Top level of the BGR to YUV 4:2:0 pixel converter.
// Depends on bgr2yuv_pkg and bgr2yuv_math.
//
// Usage:
//   Input channel (in_valid / in_stall): one BGR pixel per transaction, in
//   raster order. Output channel (out_valid / out_stall): one result per
//   pixel with luma, chroma kind (none, U, V), chroma and end_of_frame.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 frame width,
//   index 1 frame height; other indexes are ignored. Write only when idle.
//   Sizes of 0 act as 1, sizes above 4096 act as 4096.
// Pipeline: input register, then result register.
// Throughput: one pixel per cycle when not stalled; the color transform is
//   constant-coefficient math that fits between the input and result registers.
// Stalls: while the result register is stalled the input register still takes
//   one more pixel; in_stall rises only when both stages are full and the
//   receiver stalls.
// Reset: frame size returns to 640x480, column and row counters to zero,
//   both pipeline stages empty.
`default_nettype none

module bgr_to_yuv420_pixel_converter
    import bgr2yuv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]      cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [PIX_W-1:0]       blue,
    input  wire logic [PIX_W-1:0]       green,
    input  wire logic [PIX_W-1:0]       red,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [PIX_W-1:0]            luma,
    output logic [1:0]                  chroma_kind,
    output logic [PIX_W-1:0]            chroma,
    output logic                        end_of_frame
);

    // Config registers
    logic [SIZE_W-1:0] frame_width_reg, frame_height_reg;
    logic [SIZE_W-1:0] width_eff, height_eff;

    // Raster position of the next pixel
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             last_col, last_row;
    pix_tag_t         tag_next;

    // Input stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_blue_reg, s1_green_reg, s1_red_reg;
    pix_tag_t         s1_tag_reg;

    // Result stage
    logic             out_valid_reg;
    logic [PIX_W-1:0] luma_reg, chroma_reg;
    pix_tag_t         out_tag_reg;

    logic             in_fire, s1_fire, out_ready;
    logic [PIX_W-1:0] luma_calc, chroma_calc;

    // ---- Handshake ----
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_fire   = in_valid && !in_stall;

    // ---- Config writes ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
                frame_width_reg <= cfg_data;
            if (cfg_index == CFG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data;
        end
    end

    // Clamp sizes to [1, MAX_DIMENSION]
    always_comb
    begin
        width_eff = frame_width_reg;
        if (frame_width_reg == '0)
            width_eff = SIZE_W'(1);
        else if (frame_width_reg > SIZE_MAX)
            width_eff = SIZE_MAX;

        height_eff = frame_height_reg;
        if (frame_height_reg == '0)
            height_eff = SIZE_W'(1);
        else if (frame_height_reg > SIZE_MAX)
            height_eff = SIZE_MAX;
    end

    // ---- Raster counters ----
    // At-or-past the last column counts as last, so a mid-frame resize wraps.
    assign last_col = (SIZE_W'(col_reg) + SIZE_W'(1)) >= width_eff;
    assign last_row = (SIZE_W'(row_reg) + SIZE_W'(1)) >= height_eff;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + DIM_W'(1);
            end
            else
            begin
                col_next = col_reg + DIM_W'(1);
            end
        end
    end

    // U on even row / even column, V on odd row / even column
    always_comb
    begin
        if (col_reg[0])
            tag_next.kind = CHROMA_NONE;
        else if (row_reg[0])
            tag_next.kind = CHROMA_V;
        else
            tag_next.kind = CHROMA_U;
        tag_next.eof = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---- Input stage ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_blue_reg  <= blue;
            s1_green_reg <= green;
            s1_red_reg   <= red;
            s1_tag_reg   <= tag_next;
        end
    end

    // ---- Color transform ----
    bgr2yuv_math u_math (
        .blue   (s1_blue_reg),
        .green  (s1_green_reg),
        .red    (s1_red_reg),
        .kind   (s1_tag_reg.kind),
        .luma   (luma_calc),
        .chroma (chroma_calc)
    );

    // ---- Result stage ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            luma_reg    <= luma_calc;
            chroma_reg  <= chroma_calc;
            out_tag_reg <= s1_tag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_kind  = out_tag_reg.kind;
    assign chroma       = chroma_reg;
    assign end_of_frame = out_tag_reg.eof;

endmodule

`default_nettype wire
